// ----- rtl/core/fczt_pkg.sv -----
// ----------------------------------------------------------------------------
// Fan-coil zone thermostat package
// Shared request and result types, zone state, configuration and helpers.
// ----------------------------------------------------------------------------
package fczt_pkg;

    localparam int ZONES_DEFAULT = 4;

    // Configuration register indexes.
    localparam logic [1:0] CFG_AWAY_OFFSET    = 2'd0;
    localparam logic [1:0] CFG_EMPTY_COOL_REF = 2'd1;
    localparam logic [1:0] CFG_EMPTY_HEAT_REF = 2'd2;

    localparam logic [7:0] AWAY_OFFSET_RST    = 8'd0;
    localparam logic [6:0] EMPTY_COOL_REF_RST = 7'd26;
    localparam logic [6:0] EMPTY_HEAT_REF_RST = 7'd18;

    // Zone mode codes.
    localparam logic [1:0] ZMODE_EMPTY = 2'd0;
    localparam logic [1:0] ZMODE_AWAY  = 2'd1;
    localparam logic [1:0] ZMODE_STAY  = 2'd2;

    // Air-conditioner status codes.
    localparam logic [1:0] AC_ON  = 2'd1;
    localparam logic [1:0] AC_OFF = 2'd2;

    // Fan speeds.
    localparam logic [1:0] FAN_OFF  = 2'd0;
    localparam logic [1:0] FAN_LOW  = 2'd1;
    localparam logic [1:0] FAN_MID  = 2'd2;
    localparam logic [1:0] FAN_HIGH = 2'd3;

    // Gap thresholds in tenths of a degree.
    localparam logic [11:0] GAP_SMALL_MAX = 12'd9;
    localparam logic [11:0] GAP_MID_MIN   = 12'd20;
    localparam logic [11:0] GAP_HIGH_MIN  = 12'd30;

    typedef struct packed {
        logic [1:0] zone;
        logic       immediate;
        logic       timer_due;
        logic [7:0] set_code;
        logic [7:0] room_code;
        logic       cooling;
        logic       simultaneous;
        logic [1:0] occupancy;
        logic [1:0] schedule_bits;
        logic       sensor_switch;
        logic [1:0] fan_override;
    } req_t;

    typedef struct packed {
        logic [1:0] zone_out;
        logic       acted;
        logic [1:0] fan_speed;
        logic [1:0] zone_mode;
        logic [1:0] aircon_status;
        logic       mode_changed;
    } rsp_t;

    typedef struct packed {
        logic [1:0] speed;
        logic [1:0] mode;
        logic [1:0] status;
        logic [1:0] reported;
    } zone_state_t;

    typedef struct packed {
        logic [7:0] away_offset;
        logic [6:0] empty_cool_ref;
        logic [6:0] empty_heat_ref;
    } cfg_t;

    // Temperature code to tenths of a degree: degrees times ten, plus five if the half bit is set.
    function automatic logic [10:0] tenths(input logic [7:0] code);
        logic [10:0] deg;
        deg = {4'd0, code[6:0]};
        return (deg << 3) + (deg << 1) + (code[7] ? 11'd5 : 11'd0);
    endfunction

    // Whole degrees to tenths.
    function automatic logic [10:0] deg_tenths(input logic [6:0] deg);
        logic [10:0] d;
        d = {4'd0, deg};
        return (d << 3) + (d << 1);
    endfunction

    // A forced speed replaces any running speed; a stopped fan stays stopped.
    function automatic logic [1:0] fan_drive(input logic [1:0] speed,
                                             input logic [1:0] ovr);
        return (ovr == FAN_OFF || speed == FAN_OFF) ? speed : ovr;
    endfunction

endpackage

// ----- rtl/core/fczt_eval.sv -----
// ----------------------------------------------------------------------------
// Fan-coil zone evaluation
// Combinational control decision for one zone request against its state.
// ----------------------------------------------------------------------------
module fczt_eval (
    input  fczt_pkg::req_t        req,
    input  fczt_pkg::zone_state_t zs_cur,
    input  fczt_pkg::cfg_t        cfg,
    output fczt_pkg::zone_state_t zs_next,
    output logic                  acted,
    output logic                  mode_changed
);
    import fczt_pkg::*;

    logic        is_away;
    logic        is_off;
    logic        is_empty;
    logic [10:0] set_t;
    logic [10:0] room_t;
    logic [10:0] ref_t;
    logic [10:0] offs;
    logic [10:0] dem;
    logic [10:0] exc;
    logic [11:0] gap;
    logic        gap_pos;
    logic        gap_neg;
    logic        gap_big;
    logic [1:0]  band;
    logic [1:0]  ovr;

    assign acted = (req.immediate || req.timer_due) && (req.simultaneous || req.cooling);
    assign ovr   = req.fan_override;

    // Occupancy, schedule and the sensor switch select the control style.
    always_comb begin
        is_away  = 1'b0;
        is_off   = 1'b0;
        is_empty = 1'b0;
        priority if (req.occupancy[1]) begin
            if (req.schedule_bits[1]) begin
                is_away = 1'b1;
            end else if (!req.sensor_switch) begin
                is_off = 1'b1;
            end
        end else if (req.occupancy[0]) begin
            if (req.sensor_switch) begin
                is_away = 1'b1;
            end else begin
                is_off = 1'b1;
            end
        end else begin
            if (req.schedule_bits[0]) begin
                is_away = 1'b1;
            end else begin
                is_empty = 1'b1;
            end
        end
    end

    assign set_t  = tenths(req.set_code);
    assign room_t = tenths(req.room_code);
    assign ref_t  = deg_tenths(req.cooling ? cfg.empty_cool_ref : cfg.empty_heat_ref);
    assign offs   = is_away ? {3'd0, cfg.away_offset} : 11'd0;

    // Demand minus excess; in cooling a warm room is the demand.
    always_comb begin
        if (is_empty) begin
            dem = req.cooling ? room_t : ref_t;
            exc = req.cooling ? ref_t : room_t;
        end else begin
            dem = req.cooling ? room_t : set_t;
            exc = (req.cooling ? set_t : room_t) + offs;
        end
    end

    assign gap     = {1'b0, dem} - {1'b0, exc};
    assign gap_neg = gap[11];
    assign gap_pos = !gap[11] && (gap != 12'd0);
    assign gap_big = gap_pos && (gap > GAP_SMALL_MAX);

    always_comb begin
        priority if (gap >= GAP_HIGH_MIN) begin
            band = FAN_HIGH;
        end else if (gap >= GAP_MID_MIN) begin
            band = FAN_MID;
        end else begin
            band = FAN_LOW;
        end
    end

    always_comb begin
        zs_next = zs_cur;
        if (acted) begin
            priority if (is_off) begin
                zs_next.mode  = ZMODE_EMPTY;
                zs_next.speed = fan_drive(FAN_OFF, ovr);
            end else if (is_empty) begin
                zs_next.mode = ZMODE_EMPTY;
                if (gap_big) begin
                    zs_next.status = AC_ON;
                    zs_next.speed  = fan_drive(FAN_HIGH, ovr);
                end else if (!gap_pos) begin
                    if (gap_neg) begin
                        zs_next.speed = fan_drive(FAN_OFF, ovr);
                    end
                    zs_next.status = AC_OFF;
                end
            end else begin
                zs_next.mode = is_away ? ZMODE_AWAY : ZMODE_STAY;
                if (gap_big) begin
                    if (is_away) begin
                        zs_next.status = zs_cur.status | AC_ON;
                    end
                    zs_next.speed = fan_drive(band, ovr);
                end else if (gap_pos) begin
                    if (is_away) begin
                        zs_next.status = AC_OFF;
                    end
                    if (zs_cur.speed != FAN_OFF) begin
                        zs_next.speed = fan_drive(FAN_LOW, ovr);
                    end
                end else if (gap_neg) begin
                    zs_next.speed = fan_drive(FAN_OFF, ovr);
                end
            end
            zs_next.reported = zs_next.mode;
        end
    end

    assign mode_changed = acted && (zs_next.mode != zs_cur.reported);

endmodule

// ----- rtl/core/fan_coil_zone_thermostat_core.sv -----
// ----------------------------------------------------------------------------
// Fan-coil zone thermostat core
// Evaluates one zone request per cycle unless stalled; keeps per-zone fan and mode state.
// ----------------------------------------------------------------------------
// Pipeline: a request accepted into the input register is evaluated out of
// it, and its result is registered in the result register.
// Throughput: one request per cycle while the result side is not stalled,
// limited by the single evaluation stage.
// Reset: synchronous active-low aresetn clears both stages, the zone state and
// loads the configuration reset values; no clearing pass is needed.
module fan_coil_zone_thermostat_core #(
    parameter int ZONES = fczt_pkg::ZONES_DEFAULT
) (
    input  logic            aclk,
    input  logic            aresetn,
    // Request channel.
    input  logic            s_valid,
    output logic            s_ready,
    input  fczt_pkg::req_t  s_data,
    // Result channel.
    output logic            m_valid,
    input  logic            m_ready,
    output fczt_pkg::rsp_t  m_data,
    // Configuration writes.
    input  logic            cfg_we,
    input  logic [1:0]      cfg_addr,
    input  logic [7:0]      cfg_wdata
);
    import fczt_pkg::*;

    // Index width for the zone state arrays; extended zone keeps room for
    // the range check against ZONES itself.
    localparam int ZIDX_W = (ZONES > 1) ? $clog2(ZONES) : 1;
    localparam int ZEXT_W = ZIDX_W + 2;

    // Configuration registers. They must be written only while the core is idle (not enforced).
    cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.away_offset    <= AWAY_OFFSET_RST;
            cfg_reg.empty_cool_ref <= EMPTY_COOL_REF_RST;
            cfg_reg.empty_heat_ref <= EMPTY_HEAT_REF_RST;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                CFG_AWAY_OFFSET:    cfg_reg.away_offset    <= cfg_wdata;
                CFG_EMPTY_COOL_REF: cfg_reg.empty_cool_ref <= cfg_wdata[6:0];
                CFG_EMPTY_HEAT_REF: cfg_reg.empty_heat_ref <= cfg_wdata[6:0];
                default: ;
            endcase
        end
    end

    // Input stage. A request is held here while its zone is evaluated; it
    // moves on whenever the result register is empty or being drained, so a
    // new request can enter in the same cycle.
    req_t req_reg;
    logic req_valid_reg;
    logic advance;

    assign advance = req_valid_reg && (!m_valid || m_ready);
    assign s_ready = !req_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            req_valid_reg <= 1'b0;
        end else if (s_ready) begin
            req_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            req_reg <= s_data;
        end
    end

    // Zone state. The state is written at the same edge that loads the
    // result register, so the next request, even for the same zone, already
    // sees the update. No forwarding is needed.
    zone_state_t         zs_reg [ZONES];
    zone_state_t         zs_cur;
    zone_state_t         zs_next;
    logic [ZEXT_W-1:0]   zone_ext;
    logic [ZIDX_W-1:0]   zidx;
    logic                zone_ok;
    logic                eval_acted;
    logic                eval_changed;

    assign zone_ext = ZEXT_W'(req_reg.zone);
    assign zidx     = zone_ext[ZIDX_W-1:0];
    assign zone_ok  = zone_ext < ZEXT_W'(ZONES);

    always_comb begin
        if (zone_ok) begin
            zs_cur = zs_reg[zidx];
        end else begin
            zs_cur = '0;
        end
    end

    fczt_eval u_eval (
        .req          (req_reg),
        .zs_cur       (zs_cur),
        .cfg          (cfg_reg),
        .zs_next      (zs_next),
        .acted        (eval_acted),
        .mode_changed (eval_changed)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < ZONES; i++) begin
                zs_reg[i] <= '0;
            end
        end else if (advance && zone_ok) begin
            zs_reg[zidx] <= zs_next;
        end
    end

    // Result register. A zone beyond the configured count reports zeros apart from its zone number.
    rsp_t rsp_next;
    rsp_t rsp_reg;
    logic rsp_valid_reg;

    always_comb begin
        rsp_next          = '0;
        rsp_next.zone_out = req_reg.zone;
        if (zone_ok) begin
            rsp_next.acted         = eval_acted;
            rsp_next.fan_speed     = zs_next.speed;
            rsp_next.zone_mode     = zs_next.mode;
            rsp_next.aircon_status = zs_next.status;
            rsp_next.mode_changed  = eval_changed;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rsp_valid_reg <= 1'b0;
        end else if (advance) begin
            rsp_valid_reg <= 1'b1;
        end else if (m_ready) begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            rsp_reg <= rsp_next;
        end
    end

    assign m_valid = rsp_valid_reg;
    assign m_data  = rsp_reg;

endmodule

// ----- rtl/core/fczt_checker.sv -----
// ----------------------------------------------------------------------------
// Fan-coil zone thermostat checker
// Port-level assertions on the core, attached by a bind statement.
// ----------------------------------------------------------------------------
module fczt_checker (
    input logic           aclk,
    input logic           aresetn,
    input logic           s_ready,
    input logic           m_valid,
    input logic           m_ready,
    input fczt_pkg::rsp_t m_data
);
    import fczt_pkg::*;

    // Reset empties the result register.
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // A stalled result holds.
    a_rsp_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled result changed");

    // An empty result register never blocks a request.
    a_empty_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("request blocked with result register empty");

    // A mode change is reported only by an evaluated request.
    a_change_acted: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.mode_changed |-> m_data.acted)
        else $error("mode change without action");

    // An evaluated zone always reports a defined mode.
    a_mode_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.acted |->
            (m_data.zone_mode == ZMODE_EMPTY) || (m_data.zone_mode == ZMODE_AWAY) ||
            (m_data.zone_mode == ZMODE_STAY))
        else $error("undefined zone mode");

endmodule

bind fan_coil_zone_thermostat_core fczt_checker u_fczt_checker (.*);

// ----- test/testbench.sv -----
// ----------------------------------------------------------------------------
// Fan-coil zone thermostat core testbench
// Drives zone requests and configuration writes into the core, predicts every
// result with a scoreboard that keeps its own copy of the zone state, and
// compares each result field by field under random stalls on both channels.
// ----------------------------------------------------------------------------
module testbench;
    import fczt_pkg::*;

    localparam int ZONE_COUNT = 4;

    // Each request is predicted as it is accepted, and the predicted result is
    // queued until the core returns it. The scoreboard holds its own copy of
    // the configuration and of the per-zone speed, mode and unit status.
    class thermostat_scoreboard;
        logic [7:0] away_offset;
        logic [6:0] empty_cool_ref;
        logic [6:0] empty_heat_ref;
        logic [1:0] fan_of[ZONE_COUNT];
        logic [1:0] mode_of[ZONE_COUNT];
        logic [1:0] unit_of[ZONE_COUNT];
        logic [1:0] shown_mode_of[ZONE_COUNT];
        rsp_t       pending_results[$];
        int         errors;
        int         results_seen;
        int         acted_seen;
        int         changes_seen;

        function new();
            away_offset    = AWAY_OFFSET_RST;
            empty_cool_ref = EMPTY_COOL_REF_RST;
            empty_heat_ref = EMPTY_HEAT_REF_RST;
            for (int z = 0; z < ZONE_COUNT; z++) begin
                fan_of[z]        = FAN_OFF;
                mode_of[z]       = ZMODE_EMPTY;
                unit_of[z]       = 2'd0;
                shown_mode_of[z] = ZMODE_EMPTY;
            end
            errors       = 0;
            results_seen = 0;
            acted_seen   = 0;
            changes_seen = 0;
        endfunction

        function int pending();
            return pending_results.size();
        endfunction

        function void write_register(logic [1:0] index, logic [7:0] value);
            case (index)
                CFG_AWAY_OFFSET:    away_offset = value;
                CFG_EMPTY_COOL_REF: empty_cool_ref = value[6:0];
                CFG_EMPTY_HEAT_REF: empty_heat_ref = value[6:0];
                default: ;
            endcase
        endfunction

        function logic [11:0] code_tenths(logic [7:0] code);
            return 12'(code[6:0]) * 12'd10 + (code[7] ? 12'd5 : 12'd0);
        endfunction

        // A stopped fan stays stopped; a running one takes a nonzero override.
        function void set_fan(int z, logic [1:0] speed, logic [1:0] ovr);
            fan_of[z] = (speed == FAN_OFF || ovr == FAN_OFF) ? speed : ovr;
        endfunction

        function void run_bands(int z, logic [11:0] demand, logic [11:0] excess,
                                bit away, logic [1:0] ovr);
            logic [11:0] gap;
            if (demand > excess) begin
                gap = demand - excess;
                if (gap > 12'd9) begin
                    if (away) unit_of[z] = unit_of[z] | AC_ON;
                    if (gap >= 12'd30) set_fan(z, FAN_HIGH, ovr);
                    else if (gap >= 12'd20) set_fan(z, FAN_MID, ovr);
                    else set_fan(z, FAN_LOW, ovr);
                end else begin
                    if (away) unit_of[z] = AC_OFF;
                    if (fan_of[z] != FAN_OFF) set_fan(z, FAN_LOW, ovr);
                end
            end else if (demand < excess) begin
                set_fan(z, FAN_OFF, ovr);
            end
        endfunction

        function void occupied(int z, logic [11:0] set_t, logic [11:0] room_t,
                               bit cool, bit away, logic [1:0] ovr);
            mode_of[z] = away ? ZMODE_AWAY : ZMODE_STAY;
            if (away) begin
                if (cool) set_t = set_t + away_offset;
                else room_t = room_t + away_offset;
            end
            if (cool) run_bands(z, room_t, set_t, away, ovr);
            else run_bands(z, set_t, room_t, away, ovr);
        endfunction

        function void unoccupied(int z, logic [11:0] room_t, bit cool, logic [1:0] ovr);
            logic [11:0] empty_ref;
            logic [11:0] demand;
            logic [11:0] excess;
            empty_ref  = 12'(cool ? empty_cool_ref : empty_heat_ref) * 12'd10;
            demand     = cool ? room_t : empty_ref;
            excess     = cool ? empty_ref : room_t;
            mode_of[z] = ZMODE_EMPTY;
            if (demand > excess) begin
                if (demand - excess > 12'd9) begin
                    unit_of[z] = AC_ON;
                    set_fan(z, FAN_HIGH, ovr);
                end
            end else begin
                if (demand < excess) set_fan(z, FAN_OFF, ovr);
                unit_of[z] = AC_OFF;
            end
        endfunction

        function void note_request(req_t r);
            int          z;
            rsp_t        want;
            logic [11:0] set_t;
            logic [11:0] room_t;
            z              = r.zone;
            set_t          = code_tenths(r.set_code);
            room_t         = code_tenths(r.room_code);
            want           = '0;
            want.zone_out  = r.zone;
            if ((r.immediate || r.timer_due) && (r.simultaneous || r.cooling)) begin
                want.acted = 1'b1;
                if (r.occupancy[1]) begin
                    if (r.schedule_bits[1]) begin
                        occupied(z, set_t, room_t, r.cooling, 1'b1, r.fan_override);
                    end else if (r.sensor_switch) begin
                        occupied(z, set_t, room_t, r.cooling, 1'b0, r.fan_override);
                    end else begin
                        mode_of[z] = ZMODE_EMPTY;
                        fan_of[z]  = FAN_OFF;
                    end
                end else if (r.occupancy[0]) begin
                    if (r.sensor_switch) begin
                        occupied(z, set_t, room_t, r.cooling, 1'b1, r.fan_override);
                    end else begin
                        mode_of[z] = ZMODE_EMPTY;
                        fan_of[z]  = FAN_OFF;
                    end
                end else if (r.schedule_bits[0]) begin
                    occupied(z, set_t, room_t, r.cooling, 1'b1, r.fan_override);
                end else begin
                    unoccupied(z, room_t, r.cooling, r.fan_override);
                end
                if (mode_of[z] != shown_mode_of[z]) begin
                    shown_mode_of[z]  = mode_of[z];
                    want.mode_changed = 1'b1;
                end
            end
            want.fan_speed     = fan_of[z];
            want.zone_mode     = mode_of[z];
            want.aircon_status = unit_of[z];
            pending_results.push_back(want);
        endfunction

        task report(string msg);
            $display("ERROR: %s", msg);
            errors++;
        endtask

        task compare(string field, logic [1:0] got, logic [1:0] want);
            if (got !== want) begin
                report($sformatf("result %0d field %s: got %0d, expected %0d",
                                 results_seen, field, got, want));
            end
        endtask

        task check_result(rsp_t got);
            rsp_t want;
            if (pending_results.size() == 0) begin
                report($sformatf("result %h arrived with no request outstanding", got));
                return;
            end
            want = pending_results.pop_front();
            results_seen++;
            if (want.acted) acted_seen++;
            if (want.mode_changed) changes_seen++;
            compare("zone_out", got.zone_out, want.zone_out);
            compare("acted", got.acted, want.acted);
            compare("fan_speed", got.fan_speed, want.fan_speed);
            compare("zone_mode", got.zone_mode, want.zone_mode);
            compare("aircon_status", got.aircon_status, want.aircon_status);
            compare("mode_changed", got.mode_changed, want.mode_changed);
        endtask
    endclass

    logic       aclk      = 1'b0;
    logic       aresetn   = 1'b0;
    logic       s_valid   = 1'b0;
    logic       s_ready;
    req_t       s_data    = '0;
    logic       m_valid;
    logic       m_ready   = 1'b0;
    rsp_t       m_data;
    logic       cfg_we    = 1'b0;
    logic [1:0] cfg_addr  = CFG_AWAY_OFFSET;
    logic [7:0] cfg_wdata = 8'd0;

    thermostat_scoreboard sb;

    // While quiet is set, neither side idles.
    bit         quiet     = 1'b0;
    int         settings_used = 1;

    // The configuration the core holds, kept here to steer random temperatures.
    logic [7:0] cur_away  = AWAY_OFFSET_RST;
    logic [6:0] cur_cool  = EMPTY_COOL_REF_RST;
    logic [6:0] cur_heat  = EMPTY_HEAT_REF_RST;

    always #5 aclk = ~aclk;

    fan_coil_zone_thermostat_core #(
        .ZONES(ZONE_COUNT)
    ) uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    // Both handshakes are observed at the clock edge, where every signal still
    // holds the value it had before the edge, since all of them change only
    // through nonblocking assignments. The result side also stalls here.
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) sb.note_request(s_data);
        if (aresetn && m_valid && m_ready) sb.check_result(m_data);
        m_ready <= quiet || ($urandom_range(99) >= 15);
    end

    // Build one request from its fields; temperatures are given as codes.
    function automatic req_t mk(logic [1:0] zone, logic imm, logic due,
                                logic [7:0] set_c, logic [7:0] room_c,
                                logic cool, logic simul, logic [1:0] occ,
                                logic [1:0] sched, logic sensor, logic [1:0] ovr);
        req_t r;
        r.zone          = zone;
        r.immediate     = imm;
        r.timer_due     = due;
        r.set_code      = set_c;
        r.room_code     = room_c;
        r.cooling       = cool;
        r.simultaneous  = simul;
        r.occupancy     = occ;
        r.schedule_bits = sched;
        r.sensor_switch = sensor;
        r.fan_override  = ovr;
        return r;
    endfunction

    // Temperature code: whole degrees with an optional extra half degree.
    function automatic logic [7:0] tc(logic [6:0] deg, logic half);
        return {half, deg};
    endfunction

    // Most random requests are due evaluations whose room temperature lies a
    // few degrees from the point where the fan speed bands switch, so that
    // every band and both sides of it are reached. The rest is pure noise.
    function automatic req_t make_request();
        logic [31:0] raw;
        req_t r;
        bit   away;
        int   deg;
        int   shift;
        raw = $urandom();
        r   = raw[$bits(req_t)-1:0];
        if ($urandom_range(99) < 10) return r;
        {r.immediate, r.timer_due} = 2'($urandom_range(1, 3));
        r.simultaneous  = r.cooling ? 1'($urandom()) : ($urandom_range(9) != 0);
        r.sensor_switch = $urandom_range(99) < 85;
        if (r.occupancy == 2'd0 && !r.schedule_bits[0]) begin
            deg = int'(r.cooling ? cur_cool : cur_heat) + $urandom_range(6) - 3;
        end else begin
            away  = !(r.occupancy[1] && !r.schedule_bits[1]);
            shift = away ? int'(cur_away) / 10 : 0;
            deg   = int'(r.set_code[6:0]) + (r.cooling ? shift : -shift)
                    + $urandom_range(8) - 4;
        end
        if (deg < 0) deg = 0;
        if (deg > 127) deg = 127;
        r.room_code = tc(7'(deg), 1'($urandom()));
        return r;
    endfunction

    // Present one request and hold it until the core takes it. Returns at the
    // edge where it was accepted, so that the next request can follow at once.
    task send_request(input req_t r);
        while (!quiet && $urandom_range(99) < 15) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= r;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Stop sending and wait until every predicted result has come back; the
    // extra wait after that covers the two-stage pipeline.
    task drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // Writes all three registers one after another while the core is idle.
    task write_settings(input logic [7:0] away, input logic [6:0] cool_ref,
                        input logic [6:0] heat_ref);
        drain();
        cfg_we    <= 1'b1;
        cfg_addr  <= CFG_AWAY_OFFSET;
        cfg_wdata <= away;
        @(posedge aclk);
        cfg_addr  <= CFG_EMPTY_COOL_REF;
        cfg_wdata <= {1'b0, cool_ref};
        @(posedge aclk);
        cfg_addr  <= CFG_EMPTY_HEAT_REF;
        cfg_wdata <= {1'b0, heat_ref};
        @(posedge aclk);
        cfg_we    <= 1'b0;
        sb.write_register(CFG_AWAY_OFFSET, away);
        sb.write_register(CFG_EMPTY_COOL_REF, {1'b0, cool_ref});
        sb.write_register(CFG_EMPTY_HEAT_REF, {1'b0, heat_ref});
        cur_away = away;
        cur_cool = cool_ref;
        cur_heat = heat_ref;
        settings_used++;
    endtask

    initial begin
        req_t       directed[$];
        logic [7:0] away;
        logic [6:0] cool_ref;
        logic [6:0] heat_ref;

        sb = new();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed requests under the reset configuration. The stored state of
        // each zone carries over, so the order matters: a running fan is
        // needed before the small-gap case can hold it at low speed.
        directed.push_back(mk(0, 0, 0, tc(25, 0), tc(30, 0), 1, 1, 2, 0, 1, 0));
        directed.push_back(mk(0, 1, 0, tc(25, 0), tc(30, 0), 0, 0, 2, 0, 1, 0));
        directed.push_back(mk(0, 1, 0, tc(25, 0), tc(30, 0), 1, 0, 2, 0, 1, 0));
        directed.push_back(mk(0, 0, 1, tc(25, 0), tc(27, 0), 1, 0, 2, 0, 1, 0));
        directed.push_back(mk(0, 1, 1, tc(25, 0), tc(26, 0), 1, 1, 2, 0, 1, 0));
        directed.push_back(mk(0, 1, 0, tc(25, 0), tc(25, 1), 1, 0, 2, 0, 1, 2));
        directed.push_back(mk(0, 1, 0, tc(25, 0), tc(25, 0), 1, 0, 2, 0, 1, 0));
        directed.push_back(mk(0, 1, 0, tc(25, 0), tc(24, 0), 1, 0, 2, 0, 1, 3));
        directed.push_back(mk(0, 1, 0, tc(25, 0), tc(25, 1), 1, 0, 2, 0, 1, 0));
        // Heating in stay mode, then away control through the night bit.
        directed.push_back(mk(1, 1, 0, tc(22, 0), tc(18, 0), 0, 1, 2, 0, 1, 1));
        directed.push_back(mk(1, 1, 0, tc(22, 0), tc(21, 1), 0, 1, 2, 0, 1, 0));
        directed.push_back(mk(2, 1, 0, tc(24, 0), tc(28, 0), 1, 0, 2, 2, 1, 0));
        directed.push_back(mk(2, 1, 0, tc(24, 0), tc(24, 1), 1, 0, 2, 2, 1, 0));
        directed.push_back(mk(2, 0, 1, tc(24, 0), tc(20, 0), 1, 0, 2, 2, 1, 0));
        // Checked-in rooms, and the thermostat switch turned off.
        directed.push_back(mk(3, 1, 0, tc(20, 0), tc(17, 0), 0, 1, 1, 0, 1, 2));
        directed.push_back(mk(3, 1, 0, tc(20, 0), tc(17, 0), 0, 1, 1, 0, 0, 0));
        directed.push_back(mk(1, 1, 0, tc(22, 0), tc(18, 0), 0, 1, 2, 0, 0, 0));
        // Pre-conditioning of an empty room, then empty-room control.
        directed.push_back(mk(0, 1, 0, tc(24, 0), tc(29, 0), 1, 0, 0, 1, 1, 0));
        directed.push_back(mk(0, 1, 0, tc(0, 0), tc(30, 0), 1, 0, 0, 0, 1, 3));
        directed.push_back(mk(0, 1, 0, tc(0, 0), tc(26, 1), 1, 0, 0, 0, 0, 0));
        directed.push_back(mk(0, 1, 0, tc(0, 0), tc(26, 0), 1, 0, 0, 0, 1, 0));
        directed.push_back(mk(1, 1, 0, tc(0, 0), tc(20, 0), 0, 1, 0, 0, 1, 0));
        directed.push_back(mk(1, 1, 0, tc(0, 0), tc(10, 0), 0, 1, 0, 0, 1, 1));
        // Temperature codes at their extremes.
        directed.push_back(mk(2, 1, 1, 8'hff, 8'h00, 0, 1, 3, 1, 1, 3));
        directed.push_back(mk(3, 1, 1, 8'h00, 8'hff, 1, 1, 3, 3, 1, 3));
        foreach (directed[i]) send_request(directed[i]);

        // Random requests under several settings, the extremes second and third. The third
        // setting opens with a stretch where neither side idles.
        for (int p = 0; p < 5; p++) begin
            case (p)
                0: begin
                    away = 8'd9;   cool_ref = 7'd26; heat_ref = 7'd18;
                end
                1: begin
                    away = 8'd255; cool_ref = 7'd99; heat_ref = 7'd0;
                end
                2: begin
                    away = 8'd0;   cool_ref = 7'd0;  heat_ref = 7'd99;
                end
                3: begin
                    away     = 8'($urandom_range(40));
                    cool_ref = 7'($urandom_range(99));
                    heat_ref = 7'($urandom_range(99));
                end
                default: begin
                    away     = 8'($urandom_range(255));
                    cool_ref = 7'($urandom_range(99));
                    heat_ref = 7'($urandom_range(99));
                end
            endcase
            write_settings(away, cool_ref, heat_ref);
            for (int i = 0; i < 250; i++) begin
                quiet = (p == 2) && (i < 150);
                send_request(make_request());
            end
            quiet = 1'b0;
        end

        drain();
        repeat (6) @(posedge aclk);
        if (sb.pending() != 0) begin
            sb.report($sformatf("%0d predicted results never arrived", sb.pending()));
        end
        $display("Checked %0d results under %0d register settings.",
                 sb.results_seen, settings_used);
        $display("Of these, %0d were evaluations and %0d flagged a zone mode change.",
                 sb.acted_seen, sb.changes_seen);
        if (sb.errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // This guard lies far beyond the length of a correct run.
    initial begin
        #2000000;
        $display("Timeout: the core stopped taking requests or returning results.");
        $display("Simulation FAILED");
        $finish;
    end

endmodule

// ----- fan_coil_zone_thermostat_core.f -----
rtl/core/fczt_pkg.sv
rtl/core/fczt_eval.sv
rtl/core/fan_coil_zone_thermostat_core.sv
rtl/core/fczt_checker.sv
test/testbench.sv
